/* rtl/core/ffba_pkg.sv */
// ffba_pkg: types, codes and defaults shared by the first-fit allocator files
// no dependencies

package ffba_pkg;

   localparam int MAX_EXTENTS_DEF = 32;
   localparam int POOL_UNITS_DEF  = 65536;

   localparam int START_W = 16;
   localparam int LEN_W   = 17;
   localparam int ENTRY_W = START_W + LEN_W;

   localparam logic [1:0] KIND_ALLOC   = 2'd0;
   localparam logic [1:0] KIND_FREE    = 2'd1;
   localparam logic [1:0] KIND_REALLOC = 2'd2;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_NOSPACE  = 3'd1,
      STAT_NOTFOUND = 3'd2,
      STAT_FULL     = 3'd3,
      STAT_ZERO     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      MODE_FIT,
      MODE_END,
      MODE_GROW
   } mode_type;

   typedef enum logic [4:0] {
      S_IDLE, S_INIT, S_DECODE, S_U_RD, S_U_CK, S_F_RD, S_F_CK, S_TAKE,
      S_SH_RD, S_SH_WR, S_A_TAKE, S_A_PUT, S_FR_CHK, S_RA_CHK, S_RS_ACT,
      S_RG_ACT, S_RR_ACT, S_RR_REM, S_RR_PUT, S_RR_FREE, S_RA_UPD, S_DONE
   } state_type;

   typedef struct packed {
      logic               valid;
      status_type         status;
      logic [START_W-1:0] addr;
   } done_type;

endpackage

/* rtl/core/first_fit_block_allocator.sv */
// first_fit_block_allocator: top level, pool size register, result register
// depends on ffba_pkg, ffba_seq, ffba_ram
//
//   channel | dir | beat
//   req_    | in  | kind, block_addr, addr_present, request_size
//   rsp_    | out | status, result_addr
//   csr_    | in  | pool_size
//
// a request scans list entries one by one, a read state then a check state each;
// compacting a list shifts entries one by one, a read then a write state each;
// the single read port of each list memory sets this pace
// after reset and after each pool_size write, S_INIT rebuilds the free list
// req_ready is low while a request is in work; a stalled rsp_ beat holds the next one

module first_fit_block_allocator import ffba_pkg::*; #(
   parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
   parameter int POOL_UNITS  = POOL_UNITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_block_addr,
   input  logic        req_addr_present,
   input  logic [15:0] req_request_size,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_result_addr,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_pool_size
);

   localparam logic [LEN_W:0] CAP = (LEN_W+1)'(POOL_UNITS) & ~(LEN_W+1)'(3);

   logic               idle, csr_go, req_go, out_free;
   logic [LEN_W-1:0]   pool_ff, pool_in;
   logic [LEN_W:0]     rounded;
   done_type           done;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [START_W-1:0] rsp_addr_ff, rsp_addr_in;

   assign csr_ready = idle;
   assign req_ready = idle && !csr_valid;
   assign csr_go    = csr_valid && csr_ready;
   assign req_go    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rounded   = ({1'b0, csr_pool_size} + (LEN_W+1)'(3)) & ~(LEN_W+1)'(3);

   always_comb begin
      pool_in = pool_ff;
      if (csr_go) begin
         if (rounded < (LEN_W+1)'(4)) begin
            pool_in = LEN_W'(4);
         end else if (rounded > CAP) begin
            pool_in = CAP[LEN_W-1:0];
         end else begin
            pool_in = rounded[LEN_W-1:0];
         end
      end
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      if (done.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = done.status;
         rsp_addr_in   = done.addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff      <= CAP[LEN_W-1:0];
         rsp_valid_ff <= 1'b0;
      end else begin
         pool_ff      <= pool_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   ffba_seq #(.MAX_EXTENTS(MAX_EXTENTS)) u_seq (
      .clock(clock),
      .reset(reset),
      .init(csr_go),
      .go(req_go),
      .kind(req_kind),
      .block_addr(req_block_addr),
      .addr_present(req_addr_present),
      .request_size(req_request_size),
      .pool(pool_ff),
      .out_free(out_free),
      .idle(idle),
      .done(done)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_addr = rsp_addr_ff;

endmodule

/* rtl/core/ffba_ram.sv */
// ffba_ram: one write port, one registered read port extent store
// depends on ffba_pkg

module ffba_ram import ffba_pkg::*; #(
   parameter int DEPTH = MAX_EXTENTS_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [ENTRY_W-1:0]       wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [ENTRY_W-1:0]       rdata
);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/ffba_seq.sv */
// ffba_seq: sequencer that scans, edits and compacts the free and in-use lists
// depends on ffba_pkg and ffba_ram

module ffba_seq import ffba_pkg::*; #(
   parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               init,
   input  logic               go,
   input  logic [1:0]         kind,
   input  logic [15:0]        block_addr,
   input  logic               addr_present,
   input  logic [15:0]        request_size,
   input  logic [LEN_W-1:0]   pool,
   input  logic               out_free,
   output logic               idle,
   output done_type           done
);

   localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam int CW = $clog2(MAX_EXTENTS + 1);
   localparam logic [CW-1:0] CMAX = CW'(MAX_EXTENTS);

   state_type          state_ff, state_in, ret_ff, ret_in;
   mode_type           mode_ff, mode_in;
   status_type         status_ff, status_in;
   logic               sh_used_ff, sh_used_in, found_ff, found_in;
   logic [1:0]         kind_ff, kind_in;
   logic               present_ff, present_in;
   logic [LEN_W-1:0]   size_ff, size_in, hit_len_ff, hit_len_in, old_ff, old_in;
   logic [LEN_W-1:0]   end_ff, end_in, amt_ff, amt_in;
   logic [START_W-1:0] addr_ff, addr_in, hit_start_ff, hit_start_in, res_ff, res_in;
   logic [CW-1:0]      fc_ff, fc_in, uc_ff, uc_in, idx_ff, idx_in, idx_nx;
   logic [IW-1:0]      hit_idx_ff, hit_idx_in, u_ff, u_in;

   logic               f_we, u_we;
   logic [IW-1:0]      f_waddr, u_waddr, f_raddr, u_raddr;
   logic [ENTRY_W-1:0] f_wdata, u_wdata, f_rdata, u_rdata;
   logic [START_W-1:0] f_rstart, u_rstart;
   logic [LEN_W-1:0]   f_rlen, u_rlen, delta, rsize;
   logic               f_match;

   ffba_ram #(.DEPTH(MAX_EXTENTS)) u_free_ram (
      .clock(clock), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
      .raddr(f_raddr), .rdata(f_rdata)
   );

   ffba_ram #(.DEPTH(MAX_EXTENTS)) u_used_ram (
      .clock(clock), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
      .raddr(u_raddr), .rdata(u_rdata)
   );

   assign f_rstart = f_rdata[ENTRY_W-1:LEN_W];
   assign f_rlen   = f_rdata[LEN_W-1:0];
   assign u_rstart = u_rdata[ENTRY_W-1:LEN_W];
   assign u_rlen   = u_rdata[LEN_W-1:0];
   assign idx_nx   = idx_ff + CW'(1);
   assign delta    = old_ff - size_ff;
   assign rsize    = ({1'b0, request_size} + LEN_W'(3)) & ~LEN_W'(3);
   assign f_match  = ((mode_ff == MODE_END) || (f_rlen >= amt_ff)) &&
                     ((mode_ff == MODE_FIT) || ({1'b0, f_rstart} == end_ff));
   assign idle     = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         fc_ff    <= '0;
         uc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         fc_ff    <= fc_in;
         uc_ff    <= uc_in;
      end
      ret_ff       <= ret_in;
      mode_ff      <= mode_in;
      status_ff    <= status_in;
      sh_used_ff   <= sh_used_in;
      found_ff     <= found_in;
      kind_ff      <= kind_in;
      present_ff   <= present_in;
      size_ff      <= size_in;
      hit_len_ff   <= hit_len_in;
      old_ff       <= old_in;
      end_ff       <= end_in;
      amt_ff       <= amt_in;
      addr_ff      <= addr_in;
      hit_start_ff <= hit_start_in;
      res_ff       <= res_in;
      idx_ff       <= idx_in;
      hit_idx_ff   <= hit_idx_in;
      u_ff         <= u_in;
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      mode_in      = mode_ff;
      status_in    = status_ff;
      sh_used_in   = sh_used_ff;
      found_in     = found_ff;
      kind_in      = kind_ff;
      present_in   = present_ff;
      size_in      = size_ff;
      hit_len_in   = hit_len_ff;
      old_in       = old_ff;
      end_in       = end_ff;
      amt_in       = amt_ff;
      addr_in      = addr_ff;
      hit_start_in = hit_start_ff;
      res_in       = res_ff;
      fc_in        = fc_ff;
      uc_in        = uc_ff;
      idx_in       = idx_ff;
      hit_idx_in   = hit_idx_ff;
      u_in         = u_ff;
      f_we         = 1'b0;
      u_we         = 1'b0;
      f_waddr      = hit_idx_ff;
      u_waddr      = u_ff;
      f_wdata      = {hit_start_ff, hit_len_ff};
      u_wdata      = {addr_ff, size_ff};
      f_raddr      = idx_ff[IW-1:0];
      u_raddr      = idx_ff[IW-1:0];
      done.valid   = 1'b0;
      done.status  = status_ff;
      done.addr    = (status_ff == STAT_OK) ? res_ff : '0;

      unique case (state_ff)
         S_IDLE: begin
            if (init) begin
               state_in = S_INIT;
            end else if (go) begin
               kind_in    = kind;
               addr_in    = block_addr;
               present_in = addr_present;
               size_in    = rsize;
               state_in   = S_DECODE;
            end
         end
         S_INIT: begin
            f_we     = 1'b1;
            f_waddr  = '0;
            f_wdata  = {START_W'(0), pool};
            fc_in    = CW'(1);
            uc_in    = '0;
            state_in = S_IDLE;
         end
         S_DECODE: begin
            status_in = STAT_OK;
            res_in    = '0;
            idx_in    = '0;
            if ((kind_ff == KIND_ALLOC) || (kind_ff == KIND_REALLOC)) begin
               if (size_ff == '0) begin
                  status_in = STAT_ZERO;
                  state_in  = S_DONE;
               end else if ((kind_ff == KIND_ALLOC) || !present_ff) begin
                  if (uc_ff >= CMAX) begin
                     status_in = STAT_FULL;
                     state_in  = S_DONE;
                  end else begin
                     mode_in  = MODE_FIT;
                     amt_in   = size_ff;
                     ret_in   = S_A_TAKE;
                     state_in = S_F_RD;
                  end
               end else begin
                  ret_in   = S_RA_CHK;
                  state_in = S_U_RD;
               end
            end else if ((kind_ff == KIND_FREE) && present_ff) begin
               ret_in   = S_FR_CHK;
               state_in = S_U_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_U_RD: begin
            if (idx_ff >= uc_ff) begin
               found_in = 1'b0;
               state_in = ret_ff;
            end else begin
               state_in = S_U_CK;
            end
         end
         S_U_CK: begin
            if (u_rstart == addr_ff) begin
               found_in     = 1'b1;
               hit_idx_in   = idx_ff[IW-1:0];
               hit_start_in = u_rstart;
               hit_len_in   = u_rlen;
               state_in     = ret_ff;
            end else begin
               idx_in   = idx_nx;
               state_in = S_U_RD;
            end
         end
         S_F_RD: begin
            if (idx_ff >= fc_ff) begin
               found_in = 1'b0;
               state_in = ret_ff;
            end else begin
               state_in = S_F_CK;
            end
         end
         S_F_CK: begin
            if (f_match) begin
               found_in     = 1'b1;
               hit_idx_in   = idx_ff[IW-1:0];
               hit_start_in = f_rstart;
               hit_len_in   = f_rlen;
               state_in     = ret_ff;
            end else begin
               idx_in   = idx_nx;
               state_in = S_F_RD;
            end
         end
         S_TAKE: begin
            if (hit_len_ff == amt_ff) begin
               idx_in     = CW'(hit_idx_ff);
               sh_used_in = 1'b0;
               state_in   = S_SH_RD;
            end else begin
               f_we     = 1'b1;
               f_wdata  = {hit_start_ff + amt_ff[START_W-1:0], hit_len_ff - amt_ff};
               state_in = ret_ff;
            end
         end
         S_SH_RD: begin
            f_raddr = idx_nx[IW-1:0];
            u_raddr = idx_nx[IW-1:0];
            if (idx_nx >= (sh_used_ff ? uc_ff : fc_ff)) begin
               if (sh_used_ff) begin
                  uc_in = uc_ff - CW'(1);
               end else begin
                  fc_in = fc_ff - CW'(1);
               end
               state_in = ret_ff;
            end else begin
               state_in = S_SH_WR;
            end
         end
         S_SH_WR: begin
            f_we     = !sh_used_ff;
            u_we     = sh_used_ff;
            f_waddr  = idx_ff[IW-1:0];
            u_waddr  = idx_ff[IW-1:0];
            f_wdata  = f_rdata;
            u_wdata  = u_rdata;
            idx_in   = idx_nx;
            state_in = S_SH_RD;
         end
         S_A_TAKE: begin
            if (!found_ff) begin
               status_in = STAT_NOSPACE;
               state_in  = S_DONE;
            end else begin
               res_in   = hit_start_ff;
               ret_in   = S_A_PUT;
               state_in = S_TAKE;
            end
         end
         S_A_PUT: begin
            u_we     = 1'b1;
            u_waddr  = uc_ff[IW-1:0];
            u_wdata  = {res_ff, size_ff};
            uc_in    = uc_ff + CW'(1);
            state_in = S_DONE;
         end
         S_FR_CHK: begin
            if (!found_ff) begin
               status_in = STAT_NOTFOUND;
               state_in  = S_DONE;
            end else if (fc_ff >= CMAX) begin
               status_in = STAT_FULL;
               state_in  = S_DONE;
            end else begin
               f_we       = 1'b1;
               f_waddr    = fc_ff[IW-1:0];
               f_wdata    = {hit_start_ff, hit_len_ff};
               fc_in      = fc_ff + CW'(1);
               idx_in     = CW'(hit_idx_ff);
               sh_used_in = 1'b1;
               ret_in     = S_DONE;
               state_in   = S_SH_RD;
            end
         end
         S_RA_CHK: begin
            u_in   = hit_idx_ff;
            old_in = hit_len_ff;
            end_in = {1'b0, addr_ff} + hit_len_ff;
            res_in = addr_ff;
            idx_in = '0;
            if (!found_ff) begin
               status_in = STAT_NOTFOUND;
               state_in  = S_DONE;
            end else if (size_ff == hit_len_ff) begin
               state_in = S_DONE;
            end else if (size_ff < hit_len_ff) begin
               mode_in  = MODE_END;
               ret_in   = S_RS_ACT;
               state_in = S_F_RD;
            end else begin
               mode_in  = MODE_GROW;
               amt_in   = size_ff - hit_len_ff;
               ret_in   = S_RG_ACT;
               state_in = S_F_RD;
            end
         end
         S_RS_ACT: begin
            if (found_ff) begin
               f_we     = 1'b1;
               f_wdata  = {hit_start_ff - delta[START_W-1:0], hit_len_ff + delta};
               state_in = S_RA_UPD;
            end else if (fc_ff >= CMAX) begin
               status_in = STAT_FULL;
               state_in  = S_DONE;
            end else begin
               f_we     = 1'b1;
               f_waddr  = fc_ff[IW-1:0];
               f_wdata  = {addr_ff + size_ff[START_W-1:0], delta};
               fc_in    = fc_ff + CW'(1);
               state_in = S_RA_UPD;
            end
         end
         S_RG_ACT: begin
            if (found_ff) begin
               ret_in   = S_RA_UPD;
               state_in = S_TAKE;
            end else begin
               mode_in  = MODE_FIT;
               amt_in   = size_ff;
               idx_in   = '0;
               ret_in   = S_RR_ACT;
               state_in = S_F_RD;
            end
         end
         S_RR_ACT: begin
            if (!found_ff) begin
               status_in = STAT_NOSPACE;
               state_in  = S_DONE;
            end else if ((hit_len_ff != size_ff) && (fc_ff >= CMAX)) begin
               status_in = STAT_FULL;
               state_in  = S_DONE;
            end else begin
               res_in   = hit_start_ff;
               ret_in   = S_RR_REM;
               state_in = S_TAKE;
            end
         end
         S_RR_REM: begin
            idx_in     = CW'(u_ff);
            sh_used_in = 1'b1;
            ret_in     = S_RR_PUT;
            state_in   = S_SH_RD;
         end
         S_RR_PUT: begin
            u_we     = 1'b1;
            u_waddr  = uc_ff[IW-1:0];
            u_wdata  = {res_ff, size_ff};
            uc_in    = uc_ff + CW'(1);
            state_in = S_RR_FREE;
         end
         S_RR_FREE: begin
            f_we     = 1'b1;
            f_waddr  = fc_ff[IW-1:0];
            f_wdata  = {addr_ff, old_ff};
            fc_in    = fc_ff + CW'(1);
            state_in = S_DONE;
         end
         S_RA_UPD: begin
            u_we     = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               done.valid = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/ffba_checker.sv */
// ffba_checker: port-level assertions for the allocator, bound to the top level
// depends on ffba_pkg and first_fit_block_allocator

module ffba_checker import ffba_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_result_addr,
   input logic        csr_valid,
   input logic        csr_ready
);

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= STAT_ZERO))
      else $error("status code out of range");

   a_err_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_OK)) |-> (rsp_result_addr == '0))
      else $error("error beat carries an address");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready while a request is in work");

   a_init_after_csr: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> (!req_ready && !csr_ready))
      else $error("ready during list rebuild");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
      else $error("stalled result beat dropped");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_status(rsp_status),
   .rsp_result_addr(rsp_result_addr),
   .csr_valid(csr_valid),
   .csr_ready(csr_ready)
);

/* bench/ffba_checker.sv */
// ffba_scoreboard: watches the req_, rsp_ and csr_ channels of the first-fit allocator,
// predicts each result and compares it; depends on ffba_pkg

module ffba_scoreboard import ffba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_block_addr,
   input  logic        req_addr_present,
   input  logic [15:0] req_request_size,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_status,
   input  logic [15:0] rsp_result_addr,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [16:0] csr_pool_size,
   output int          fail_count,
   output int          pending,
   output int          live_blocks,
   output int          live_addr [0:31]
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      status_type status;
      logic [15:0] addr;
   } alloc_result_type;

   localparam int NX = MAX_EXTENTS_DEF;

   int unsigned pool;
   int unsigned fs [NX];
   int unsigned fl [NX];
   int unsigned fc;
   int unsigned us [NX];
   int unsigned ul [NX];
   int unsigned uc;
   alloc_result_type expected_q [$];

   function automatic int unsigned up4(int unsigned x);
      return (x + 3) & ~32'd3;
   endfunction

   task automatic rebuild_lists();
      for (int i = 0; i < NX; i++) begin
         fs[i] = 0; fl[i] = 0; us[i] = 0; ul[i] = 0;
      end
      fl[0] = pool;
      fc = 1;
      uc = 0;
   endtask

   function automatic void drop_free(int unsigned i);
      while (i + 1 < fc) begin
         fs[i] = fs[i+1]; fl[i] = fl[i+1];
         i++;
      end
      fc--;
   endfunction

   function automatic void drop_used(int unsigned i);
      while (i + 1 < uc) begin
         us[i] = us[i+1]; ul[i] = ul[i+1];
         i++;
      end
      uc--;
   endfunction

   function automatic int unsigned fit_index(int unsigned size);
      for (int unsigned i = 0; i < fc; i++)
         if (fl[i] >= size) return i;
      return fc;
   endfunction

   function automatic int unsigned carve(int unsigned i, int unsigned size);
      int unsigned s;
      s = fs[i];
      if (fl[i] == size) drop_free(i);
      else begin
         fs[i] += size;
         fl[i] -= size;
      end
      return s;
   endfunction

   function automatic int unsigned owner(int unsigned a);
      for (int unsigned i = 0; i < uc; i++)
         if (us[i] == a) return i;
      return uc;
   endfunction

   function automatic status_type grant(int unsigned size, ref int unsigned a);
      int unsigned i;
      if (uc >= NX) return STAT_FULL;
      i = fit_index(size);
      if (i >= fc) return STAT_NOSPACE;
      a = carve(i, size);
      us[uc] = a; ul[uc] = size; uc++;
      return STAT_OK;
   endfunction

   function automatic status_type release_block(int unsigned a);
      int unsigned u;
      u = owner(a);
      if (u >= uc) return STAT_NOTFOUND;
      if (fc >= NX) return STAT_FULL;
      fs[fc] = us[u]; fl[fc] = ul[u]; fc++;
      drop_used(u);
      return STAT_OK;
   endfunction

   function automatic status_type resize(int unsigned a, int unsigned size,
                                         ref int unsigned na);
      int unsigned u, old, tail, f, os, ol, d;
      u = owner(a);
      if (u >= uc) return STAT_NOTFOUND;
      old = ul[u];
      tail = a + old;
      na = a;
      if (size == old) return STAT_OK;
      if (size < old) begin
         d = old - size;
         for (int unsigned i = 0; i < fc; i++)
            if (fs[i] == tail) begin
               fs[i] -= d; fl[i] += d; ul[u] = size;
               return STAT_OK;
            end
         if (fc >= NX) return STAT_FULL;
         fs[fc] = a + size; fl[fc] = d; fc++;
         ul[u] = size;
         return STAT_OK;
      end
      d = size - old;
      for (int unsigned i = 0; i < fc; i++)
         if (fs[i] == tail && fl[i] >= d) begin
            void'(carve(i, d));
            ul[u] = size;
            return STAT_OK;
         end
      f = fit_index(size);
      if (f >= fc) return STAT_NOSPACE;
      if (fl[f] != size && fc >= NX) return STAT_FULL;
      os = us[u]; ol = ul[u];
      na = carve(f, size);
      drop_used(u);
      us[uc] = na; ul[uc] = size; uc++;
      fs[fc] = os; fl[fc] = ol; fc++;
      return STAT_OK;
   endfunction

   function automatic alloc_result_type predict(logic [1:0] kind, logic [15:0] a,
                                                logic present, logic [15:0] rs);
      alloc_result_type r;
      int unsigned size, res;
      size = up4(rs);
      res = 0;
      r.status = STAT_OK;
      if (kind == KIND_ALLOC || kind == KIND_REALLOC) begin
         if (size == 0) r.status = STAT_ZERO;
         else if (kind == KIND_ALLOC || !present) r.status = grant(size, res);
         else r.status = resize(a, size, res);
      end else if (kind == KIND_FREE) begin
         if (present) r.status = release_block(a);
      end
      r.addr = (r.status == STAT_OK) ? res[15:0] : 16'd0;
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type e;
      int unsigned v;
      if (reset) begin
         pool = POOL_UNITS_DEF & ~32'd3;
         rebuild_lists();
         expected_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            v = up4(csr_pool_size);
            if (v < 4) v = 4;
            if (v > (POOL_UNITS_DEF & ~32'd3)) v = POOL_UNITS_DEF & ~32'd3;
            pool = v;
            rebuild_lists();
         end
         if (req_valid && req_ready)
            expected_q.insert(expected_q.size(),
                              predict(req_kind, req_block_addr, req_addr_present,
                                      req_request_size));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected rsp beat: status %0d addr %0d",
                           rsp_status, rsp_result_addr);
            end else begin
               e = expected_q.pop_front();
               if (rsp_status !== e.status || rsp_result_addr !== e.addr) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch at %0t: status exp %0d got %0d, addr exp %0d got %0d",
                              $realtime, e.status, rsp_status, e.addr, rsp_result_addr);
               end
            end
         end
      end
      pending = expected_q.size();
      live_blocks = uc;
      for (int i = 0; i < 32; i++) live_addr[i] = us[i];
   end
endmodule

/* bench/tb_first_fit_block_allocator.sv */
// tb_first_fit_block_allocator: stimulus and verdict for the first-fit allocator
// depends on ffba_pkg, first_fit_block_allocator and ffba_scoreboard

module tb_first_fit_block_allocator;
   import ffba_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_kind = KIND_ALLOC;
   logic [15:0] req_block_addr = 0;
   logic        req_addr_present = 0;
   logic [15:0] req_request_size = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_result_addr;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [16:0] csr_pool_size = 0;
   int          fail_count, pending, live_blocks;
   int          live_addr [0:31];
   int          hold_cycles = 0;

   first_fit_block_allocator uut (.*);
   ffba_scoreboard chk (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver: random stall per beat, plus a long hold-off on request
   initial begin
      int w;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_ready <= 0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         if (w > 0) begin
            rsp_ready <= 0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send(logic [1:0] k, logic [15:0] a, logic p, logic [15:0] s,
                       int gap);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= k;
      req_block_addr <= a;
      req_addr_present <= p;
      req_request_size <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_pool(logic [16:0] v);
      drain();
      repeat (300) @(posedge clock);
      csr_valid <= 1;
      csr_pool_size <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_addr();
      if (live_blocks > 0 && $urandom_range(0, 7) != 0)
         return 16'(live_addr[$urandom_range(0, live_blocks - 1)]);
      return 16'($urandom);
   endfunction

   task automatic random_items(int n, int max_size);
      int r, g;
      logic [15:0] s;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         s = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, max_size));
         if (r < 40) send(KIND_ALLOC, 16'($urandom), 1'($urandom), s, g);
         else if (r < 70) send(KIND_FREE, pick_addr(), $urandom_range(0, 15) != 0, s, g);
         else if (r < 97) send(KIND_REALLOC, pick_addr(), $urandom_range(0, 9) != 0, s, g);
         else send(KIND_UNUSED, 16'($urandom), 1'($urandom), s, g);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      send(KIND_ALLOC, 0, 0, 0, 0);
      send(KIND_ALLOC, 0, 0, 16'hFFFF, 0);
      send(KIND_ALLOC, 16'hFFFF, 1, 1, 0);
      send(KIND_ALLOC, 0, 0, 5, 0);
      send(KIND_ALLOC, 0, 0, 8, 0);
      send(KIND_REALLOC, 4, 1, 8, 0);
      send(KIND_REALLOC, 4, 1, 4, 0);
      send(KIND_REALLOC, 4, 1, 12, 0);
      send(KIND_REALLOC, 0, 1, 40, 0);
      send(KIND_REALLOC, 0, 0, 3, 0);
      send(KIND_REALLOC, 16'h1234, 1, 4, 0);
      send(KIND_REALLOC, 4, 1, 0, 0);
      send(KIND_FREE, 16'h1234, 1, 0, 0);
      send(KIND_FREE, 0, 0, 0, 0);
      send(KIND_FREE, 4, 1, 0, 0);
      send(KIND_UNUSED, 16'hFFFF, 1, 16'hFFFF, 0);
      // long hold-off while the sender keeps offering
      hold_cycles = 400;
      for (int i = 0; i < 6; i++) send(KIND_ALLOC, 0, 0, 4, 0);
      // sender pauses until all results are in
      drain();
      write_pool(17'd0);
      send(KIND_ALLOC, 0, 0, 4, 0);
      send(KIND_ALLOC, 0, 0, 1, 0);
      write_pool(17'h1FFFF);
      random_items(250, 2000);
      write_pool(17'd130);
      for (int i = 0; i < 34; i++) send(KIND_ALLOC, 0, 0, 4, 0);
      for (int i = 0; i < 34; i++) send(KIND_FREE, 16'(4 * i), 1, 0, 0);
      random_items(200, 12);
      write_pool(17'd2047);
      random_items(300, 120);
      drain();
      repeat (300) @(posedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

/* sim.f */
rtl/core/ffba_pkg.sv
rtl/core/ffba_ram.sv
rtl/core/ffba_seq.sv
rtl/core/first_fit_block_allocator.sv
rtl/core/ffba_checker.sv
bench/ffba_checker.sv
bench/tb_first_fit_block_allocator.sv
